@@ hw/rtl/ypd_pkg.sv @@
// Package for the yaw/pitch to direction block: sequencer state type and
// the fixed constants of the angle divider and the CORDIC unit.
// No dependencies.
package ypd_pkg;

   // sequencer states, one-hot
   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_WRAP = 5'b00010,
      ST_DIV  = 5'b00100,
      ST_ROT  = 5'b01000,
      ST_MUL  = 5'b10000
   } seq_state_type;

   // A full turn is 45 * 2^(F+3) angle units, so the binary angle
   // round(u * 2^32 / turn) is floor((u * 2^(29-F) + 22) / 45).
   localparam int DIVISOR    = 45;
   localparam int ROUND_BIAS = 22;
   localparam int DIV_W      = 39;   // dividend width, three bits per digit
   localparam int DIV_DIGITS = 13;   // radix-8 digits in the dividend
   localparam int REM_W      = 6;    // remainder below the divisor
   localparam int DIGIT_W    = 3;

   localparam int BANG_W     = 32;   // binary angle, 2^32 per turn
   localparam int CORD_W     = 33;   // CORDIC x, y, z registers
   localparam int TRIG_W     = 32;   // stored sine and cosine, Q2.30
   localparam int ATAN_IDX_W = 5;
   localparam int ATAN_LEN   = 24;

   localparam logic [31:0] CORDIC_GAIN = 32'd652032874;

   // arctangent of 2^-i as a binary angle
   function automatic logic [31:0] atan_entry(input logic [ATAN_IDX_W-1:0] idx);
      logic [31:0] val;
      case (idx)
         5'd0:    val = 32'd536870912;
         5'd1:    val = 32'd316933406;
         5'd2:    val = 32'd167458907;
         5'd3:    val = 32'd85004756;
         5'd4:    val = 32'd42667331;
         5'd5:    val = 32'd21354465;
         5'd6:    val = 32'd10679838;
         5'd7:    val = 32'd5340245;
         5'd8:    val = 32'd2670163;
         5'd9:    val = 32'd1335087;
         5'd10:   val = 32'd667544;
         5'd11:   val = 32'd333772;
         5'd12:   val = 32'd166886;
         5'd13:   val = 32'd83443;
         5'd14:   val = 32'd41722;
         5'd15:   val = 32'd20861;
         5'd16:   val = 32'd10430;
         5'd17:   val = 32'd5215;
         5'd18:   val = 32'd2608;
         5'd19:   val = 32'd1304;
         5'd20:   val = 32'd652;
         5'd21:   val = 32'd326;
         5'd22:   val = 32'd163;
         5'd23:   val = 32'd81;
         default: val = 32'd0;
      endcase
      return val;
   endfunction

endpackage

@@ hw/rtl/yaw_pitch_to_direction.sv @@
// Top level of the yaw/pitch to direction block: angle accumulation, binary
// angle divider, shared CORDIC rotator and product stage.
// Depends on ypd_pkg.
//
//  channel | ports                                  | direction
//  --------+----------------------------------------+----------
//  req     | req_valid/req_stall, yaw/pitch delta   | in
//  rsp     | rsp_valid/rsp_stall, dir_x/y/z, clamp  | out
//
// The rotator runs its CORDIC_STEPS iterations twice, each after a 13-digit
// radix-8 divide.
// Reset clears both angles and drops any pending result.
// A stalled result is held; the next item is taken meanwhile and waits at
// its final step until the result register frees.
module yaw_pitch_to_direction #(
   parameter int ANGLE_FRAC_BITS = 7,
   parameter int OUT_FRAC_BITS   = 15,
   parameter int CORDIC_STEPS    = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_yaw_delta,
   input  logic signed [15:0] req_pitch_delta,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_dir_x,
   output logic signed [15:0] rsp_dir_y,
   output logic signed [15:0] rsp_dir_z,
   output logic               rsp_pitch_clamped
);
   import ypd_pkg::*;

   localparam int FULL_TURN = 360 << ANGLE_FRAC_BITS;
   localparam int PITCH_LIM = 89 << ANGLE_FRAC_BITS;
   localparam int UW        = $clog2(FULL_TURN);
   localparam int YS_W      = $clog2(FULL_TURN + 32768) + 1;
   localparam int PITCH_W   = $clog2(PITCH_LIM + 1) + 1;
   localparam int PSUM_W    = $clog2(PITCH_LIM + 32768 + 1) + 1;
   localparam int DSH       = 29 - ANGLE_FRAC_BITS;
   localparam int OSH       = 30 - OUT_FRAC_BITS;
   localparam int CNT_MAX   = (CORDIC_STEPS > DIV_DIGITS) ? CORDIC_STEPS : DIV_DIGITS;
   localparam int CNT_W     = $clog2(CNT_MAX);

   localparam logic signed [YS_W-1:0]   FT_S  = YS_W'(FULL_TURN);
   localparam logic signed [PSUM_W-1:0] PLIM  = PSUM_W'(PITCH_LIM);
   localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_DIGITS - 1);
   localparam logic [CNT_W-1:0] ROT_LAST = CNT_W'(CORDIC_STEPS - 1);
   localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(2);

   // Q2.30 to output format with half-up rounding and 16-bit saturation
   function automatic logic signed [15:0] to_out(input logic signed [33:0] v);
      logic signed [34:0] t;
      logic signed [34:0] r;
      logic signed [15:0] o;
      t = 35'(v) + (35'sd1 <<< (OSH - 1));
      r = t >>> OSH;
      if (r > 35'sd32767) begin
         o = 16'sh7fff;
      end else if (r < -35'sd32768) begin
         o = -16'sh8000;
      end else begin
         o = 16'(r);
      end
      return o;
   endfunction

   function automatic logic signed [33:0] round_q30(input logic signed [63:0] p);
      logic signed [63:0] t;
      t = p + (64'sd1 <<< 29);
      return $signed(t[63:30]);
   endfunction

   // control registers
   seq_state_type            state_ff, state_in;
   logic                     sel_ff, sel_in;         // 0: yaw pass, 1: pitch pass
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic [UW-1:0]            yaw_ff, yaw_in;
   logic signed [PITCH_W-1:0] pitch_ff, pitch_in;
   logic                     out_valid_ff, out_valid_in;

   // work registers
   logic signed [YS_W-1:0]   ys_ff, ys_in;
   logic                     clamp_ff, clamp_in;
   logic [DIV_W-1:0]         ds_ff, ds_in;
   logic [REM_W-1:0]         rem_ff, rem_in;
   logic [BANG_W-1:0]        q_ff, q_in;
   logic signed [CORD_W-1:0] z_ff, z_in, x_ff, x_in, y_ff, y_in;
   logic                     neg_ff, neg_in;
   logic signed [TRIG_W-1:0] cy_ff, cy_in, sy_ff, sy_in, cp_ff, cp_in, sp_ff, sp_in;
   logic signed [63:0]       prod_ff, prod_in;
   logic signed [15:0]       wx_ff, wx_in;
   logic signed [15:0]       dx_ff, dx_in, dy_ff, dy_in, dz_ff, dz_in;
   logic                     oclamp_ff, oclamp_in;

   // combinational helpers
   logic                     accept;
   logic signed [PSUM_W-1:0] psum;
   logic signed [YS_W-1:0]   pu_wide;
   logic [UW-1:0]            div_u;
   logic [DIV_W-1:0]         div_load;
   logic [8:0]               dv;
   logic [DIGIT_W-1:0]       dig;
   logic [REM_W-1:0]         drem;
   logic [BANG_W-1:0]        q_full;
   logic signed [BANG_W-1:0] zq;
   logic                     zflip;
   logic signed [CORD_W-1:0] xsh, ysh, atan_s, xn, yn, xr, yr;
   logic signed [TRIG_W-1:0] mul_a;
   logic signed [63:0]       prod_w;
   logic                     out_free;

   assign req_stall         = (state_ff != ST_IDLE);
   assign accept            = req_valid && !req_stall;
   assign rsp_valid         = out_valid_ff;
   assign rsp_dir_x         = dx_ff;
   assign rsp_dir_y         = dy_ff;
   assign rsp_dir_z         = dz_ff;
   assign rsp_pitch_clamped = oclamp_ff;
   assign out_free          = !(out_valid_ff && rsp_stall);

   always_comb begin
      psum    = PSUM_W'(pitch_ff) + PSUM_W'(req_pitch_delta);
      pu_wide = (pitch_ff < 0) ? YS_W'(pitch_ff) + FT_S : YS_W'(pitch_ff);
      div_u   = (state_ff == ST_WRAP) ? UW'(ys_ff) : UW'(pu_wide);
      div_load = (DIV_W'(div_u) << DSH) + DIV_W'(ROUND_BIAS);

      // one radix-8 quotient digit
      dv   = {rem_ff, ds_ff[DIV_W-1 -: DIGIT_W]};
      dig  = '0;
      drem = REM_W'(dv);
      for (int k = 1; k < 8; k++) begin
         if (dv >= 9'(k * DIVISOR)) begin
            dig  = DIGIT_W'(k);
            drem = REM_W'(dv - 9'(k * DIVISOR));
         end
      end
      q_full = {q_ff[BANG_W-DIGIT_W-1:0], dig};
      zq     = $signed(q_full);
      // beyond a quarter turn: rotate by half a turn and negate the result
      zflip  = (zq > 32'sd1073741824) || (zq < -32'sd1073741824);

      // CORDIC iteration
      xsh    = x_ff >>> cnt_ff;
      ysh    = y_ff >>> cnt_ff;
      atan_s = $signed({1'b0, atan_entry(ATAN_IDX_W'(cnt_ff))});
      if (z_ff >= 0) begin
         xn = x_ff - ysh;
         yn = y_ff + xsh;
      end else begin
         xn = x_ff + ysh;
         yn = y_ff - xsh;
      end
      xr = neg_ff ? -xn : xn;
      yr = neg_ff ? -yn : yn;

      mul_a  = (cnt_ff == '0) ? cy_ff : sy_ff;
      prod_w = mul_a * cp_ff;
   end

   always_comb begin
      state_in     = state_ff;
      sel_in       = sel_ff;
      cnt_in       = cnt_ff;
      yaw_in       = yaw_ff;
      pitch_in     = pitch_ff;
      out_valid_in = out_valid_ff;
      ys_in        = ys_ff;
      clamp_in     = clamp_ff;
      ds_in        = ds_ff;
      rem_in       = rem_ff;
      q_in         = q_ff;
      z_in         = z_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      neg_in       = neg_ff;
      cy_in        = cy_ff;
      sy_in        = sy_ff;
      cp_in        = cp_ff;
      sp_in        = sp_ff;
      prod_in      = prod_ff;
      wx_in        = wx_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      dz_in        = dz_ff;
      oclamp_in    = oclamp_ff;

      if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               ys_in = YS_W'($signed({1'b0, yaw_ff})) + YS_W'(req_yaw_delta);
               if (psum > PLIM) begin
                  pitch_in = PITCH_W'(PLIM);
                  clamp_in = 1'b1;
               end else if (psum < -PLIM) begin
                  pitch_in = PITCH_W'(-PLIM);
                  clamp_in = 1'b1;
               end else begin
                  pitch_in = PITCH_W'(psum);
                  clamp_in = 1'b0;
               end
               state_in = ST_WRAP;
            end
         end
         ST_WRAP: begin
            // add or remove one turn per cycle until the yaw sum lies in range
            if (ys_ff < 0) begin
               ys_in = ys_ff + FT_S;
            end else if (ys_ff >= FT_S) begin
               ys_in = ys_ff - FT_S;
            end else begin
               yaw_in   = UW'(ys_ff);
               ds_in    = div_load;
               rem_in   = '0;
               cnt_in   = '0;
               sel_in   = 1'b0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            ds_in  = ds_ff << DIGIT_W;
            rem_in = drem;
            q_in   = q_full;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DIV_LAST) begin
               z_in     = zflip ? CORD_W'($signed({~q_full[BANG_W-1], q_full[BANG_W-2:0]}))
                                : CORD_W'(zq);
               neg_in   = zflip;
               x_in     = CORD_W'($signed(CORDIC_GAIN));
               y_in     = '0;
               cnt_in   = '0;
               state_in = ST_ROT;
            end
         end
         ST_ROT: begin
            x_in   = xn;
            y_in   = yn;
            z_in   = (z_ff >= 0) ? z_ff - atan_s : z_ff + atan_s;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == ROT_LAST) begin
               cnt_in = '0;
               if (!sel_ff) begin
                  cy_in    = TRIG_W'(xr);
                  sy_in    = TRIG_W'(yr);
                  sel_in   = 1'b1;
                  ds_in    = div_load;
                  rem_in   = '0;
                  state_in = ST_DIV;
               end else begin
                  cp_in    = TRIG_W'(xr);
                  sp_in    = TRIG_W'(yr);
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            if (cnt_ff != MUL_LAST) begin
               prod_in = prod_w;
               cnt_in  = cnt_ff + 1'b1;
               if (cnt_ff != '0) begin
                  wx_in = to_out(round_q30(prod_ff));
               end
            end else if (out_free) begin
               dx_in        = wx_ff;
               dy_in        = to_out(34'(sp_ff));
               dz_in        = to_out(round_q30(prod_ff));
               oclamp_in    = clamp_ff;
               out_valid_in = 1'b1;
               cnt_in       = '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sel_ff       <= 1'b0;
         cnt_ff       <= '0;
         yaw_ff       <= '0;
         pitch_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sel_ff       <= sel_in;
         cnt_ff       <= cnt_in;
         yaw_ff       <= yaw_in;
         pitch_ff     <= pitch_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ys_ff     <= ys_in;
      clamp_ff  <= clamp_in;
      ds_ff     <= ds_in;
      rem_ff    <= rem_in;
      q_ff      <= q_in;
      z_ff      <= z_in;
      x_ff      <= x_in;
      y_ff      <= y_in;
      neg_ff    <= neg_in;
      cy_ff     <= cy_in;
      sy_ff     <= sy_in;
      cp_ff     <= cp_in;
      sp_ff     <= sp_in;
      prod_ff   <= prod_in;
      wx_ff     <= wx_in;
      dx_ff     <= dx_in;
      dy_ff     <= dy_in;
      dz_ff     <= dz_in;
      oclamp_ff <= oclamp_in;
   end

endmodule
